/* sv/rqcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rqcp_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CODEW = 8;
  localparam int CAPW  = 5;
  localparam int OCCW  = 5;
  localparam int KINDW = 2;

  typedef enum logic [KINDW-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_PRO = 2'd2,
    KIND_NOP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_COPY,
    ST_MATCH,
    ST_REST
  } state_e;

  typedef struct packed {
    logic ok;
    logic [CODEW-1:0] code;
    logic [OCCW-1:0] occ;
  } result_t;

  typedef struct packed {
    logic we;
    logic [AW-1:0] waddr;
    logic [CODEW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] cap);
    logic [CW:0] nx;
    nx = (CW + 1)'(idx) + (CW + 1)'(1);
    return (nx >= (CW + 1)'(cap)) ? '0 : nx[AW-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/ring_queue_with_class_promote_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Valid/ready                  | Payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser kind, tdata code
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser ok, tdata code_out, occupancy
// cfg       | in        | cfg_we_i (no ready)          | cfg_wdata_i capacity
//
// Enqueue, an empty dequeue and an unused kind are handled in the idle state; a dequeue that
// finds an entry passes through ST_DEQ to take the registered read of the slot memory.
// Promote on an empty queue returns ok from the idle state; otherwise one pass copies the queue
// to a scratch memory, then two passes write back matching and then other entries.
// The input is not ready while an item is at work or while a result waits and m_axis_tready
// is low. Reset clears the capacity, head and count; the slot memory needs no clearing.

module ring_queue_with_class_promote_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] code
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] code_out, [12:8] occupancy
  output logic             m_axis_tuser    // [0] ok
);

  import rqcp_pkg::*;

  result_t          result;
  ram_req_t         slot_req;
  ram_req_t         ord_req;
  logic [CODEW-1:0] slot_rdata;
  logic [CODEW-1:0] ord_rdata;

  rqcp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (kind_e'(s_axis_tuser)),
    .code_i       (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result),
    .slot_req_o   (slot_req),
    .slot_rdata_i (slot_rdata),
    .ord_req_o    (ord_req),
    .ord_rdata_i  (ord_rdata)
  );

  rqcp_ram #(
    .WIDTH (CODEW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_req.we),
    .waddr_i (slot_req.waddr),
    .wdata_i (slot_req.wdata),
    .raddr_i (slot_req.raddr),
    .rdata_o (slot_rdata)
  );

  rqcp_ram #(
    .WIDTH (CODEW),
    .DEPTH (DEPTH)
  ) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_req.we),
    .waddr_i (ord_req.waddr),
    .wdata_i (ord_req.wdata),
    .raddr_i (ord_req.raddr),
    .rdata_o (ord_rdata)
  );

  assign m_axis_tdata = {3'b000, result.occ, result.code};
  assign m_axis_tuser = result.ok;

endmodule

`default_nettype wire

/* sv/rqcp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rqcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/rqcp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rqcp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rqcp_pkg::CAPW-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire rqcp_pkg::kind_e            kind_i,
  input  wire logic [rqcp_pkg::CODEW-1:0] code_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rqcp_pkg::result_t               result_o,
  output rqcp_pkg::ram_req_t              slot_req_o,
  input  wire logic [rqcp_pkg::CODEW-1:0] slot_rdata_i,
  output rqcp_pkg::ram_req_t              ord_req_o,
  input  wire logic [rqcp_pkg::CODEW-1:0] ord_rdata_i
);

  import rqcp_pkg::*;

  state_e           state_q, state_d;
  logic [CAPW-1:0]  cap_q, cap_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    rk_q, rk_d;
  logic [CW-1:0]    wk_q, wk_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    ridx_q, ridx_d;
  logic [AW-1:0]    widx_q, widx_d;
  logic [CODEW-1:0] cls_q, cls_d;
  logic             ov_q, ov_d;
  result_t          res_q, res_d;

  logic [CW-1:0]    eff_cap;
  logic [CW:0]      pos_sum;
  logic [AW-1:0]    enq_pos;
  logic             accept;
  logic             hit;

  assign eff_cap = (32'(cap_q) > DEPTH) ? CW'(DEPTH) : CW'(cap_q);
  assign pos_sum = (CW + 1)'(head_q) + (CW + 1)'(cnt_q);
  assign enq_pos = (cnt_q == '0) ? '0 :
                   (pos_sum >= (CW + 1)'(eff_cap)) ?
                   AW'(pos_sum - (CW + 1)'(eff_cap)) : AW'(pos_sum);

  assign in_ready_o = (state_q == ST_IDLE) && (!ov_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = (ord_rdata_i == cls_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      rk_q    <= '0;
      wk_q    <= '0;
      rv_q    <= 1'b0;
      ridx_q  <= '0;
      widx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rk_q    <= rk_d;
      wk_q    <= wk_d;
      rv_q    <= rv_d;
      ridx_q  <= ridx_d;
      widx_q  <= widx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cap_d   = cap_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    rk_d    = rk_q;
    wk_d    = wk_q;
    rv_d    = 1'b0;
    ridx_d  = ridx_q;
    widx_d  = widx_q;
    cls_d   = cls_q;
    ov_d    = ov_q && !out_ready_i;
    res_d   = res_q;

    slot_req_o.we    = 1'b0;
    slot_req_o.waddr = enq_pos;
    slot_req_o.wdata = code_i;
    slot_req_o.raddr = head_q;
    ord_req_o.we     = 1'b0;
    ord_req_o.waddr  = wk_q[AW-1:0];
    ord_req_o.wdata  = slot_rdata_i;
    ord_req_o.raddr  = rk_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.ok   = 1'b0;
          res_d.code = '0;
          res_d.occ  = OCCW'(cnt_q);
          case (kind_i)
            KIND_ENQ: begin
              ov_d = 1'b1;
              if (cnt_q < eff_cap) begin
                slot_req_o.we = 1'b1;
                if (cnt_q == '0) begin
                  head_d = '0;
                end
                cnt_d     = cnt_q + CW'(1);
                res_d.ok  = 1'b1;
                res_d.occ = OCCW'(cnt_q + CW'(1));
              end
            end
            KIND_DEQ: begin
              if (cnt_q != '0) begin
                state_d = ST_DEQ;
              end else begin
                ov_d = 1'b1;
              end
            end
            KIND_PRO: begin
              cls_d = code_i;
              if (cnt_q != '0) begin
                state_d = ST_COPY;
                rk_d    = '0;
                wk_d    = '0;
                ridx_d  = head_q;
              end else begin
                ov_d     = 1'b1;
                res_d.ok = 1'b1;
              end
            end
            default: begin
              ov_d = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        res_d.ok   = 1'b1;
        res_d.code = slot_rdata_i;
        res_d.occ  = OCCW'(cnt_q - CW'(1));
        head_d     = wrap_next(head_q, eff_cap);
        cnt_d      = cnt_q - CW'(1);
        ov_d       = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_COPY: begin
        slot_req_o.raddr = ridx_q;
        if (rk_q < cnt_q) begin
          rk_d   = rk_q + CW'(1);
          ridx_d = wrap_next(ridx_q, eff_cap);
          rv_d   = 1'b1;
        end
        if (rv_q) begin
          ord_req_o.we = 1'b1;
          wk_d         = wk_q + CW'(1);
        end
        if (rk_q == cnt_q && !rv_q) begin
          state_d = ST_MATCH;
          rk_d    = '0;
          widx_d  = head_q;
        end
      end
      ST_MATCH, ST_REST: begin
        slot_req_o.waddr = widx_q;
        slot_req_o.wdata = ord_rdata_i;
        if (rk_q < cnt_q) begin
          rk_d = rk_q + CW'(1);
          rv_d = 1'b1;
        end
        if (rv_q && (hit == (state_q == ST_MATCH))) begin
          slot_req_o.we = 1'b1;
          widx_d        = wrap_next(widx_q, eff_cap);
        end
        if (rk_q == cnt_q && !rv_q) begin
          rk_d = '0;
          if (state_q == ST_MATCH) begin
            state_d = ST_REST;
          end else begin
            state_d    = ST_IDLE;
            res_d.ok   = 1'b1;
            res_d.code = '0;
            res_d.occ  = OCCW'(cnt_q);
            ov_d       = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      cap_d  = cfg_wdata_i;
      head_d = '0;
      cnt_d  = '0;
    end
  end

  assign out_valid_o = ov_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire
